/* hdl/prdf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prdf_pkg: shared types and constants of the padded record deframer
// result record layout, result kinds, parse phases and the handler check
// ----------------------------------------------------------------------------
package prdf_pkg;

  localparam int HANDLER_SLOTS = 20;
  localparam int SIZE_W        = 10;
  localparam int HANDLER_W     = 5;
  localparam int BYTE_W        = 8;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_MARKER  = 2'd1;
  localparam logic [1:0] KIND_STATUS  = 2'd2;

  // parse phase, one-hot
  typedef enum logic [2:0] {
    PH_BOUNDARY = 3'b001,
    PH_HDR_HIGH = 3'b010,
    PH_PAYLOAD  = 3'b100
  } phase_t;

  // one result item
  typedef struct packed {
    logic [1:0]           kind;
    logic [HANDLER_W-1:0] handler_index;
    logic [SIZE_W-1:0]    record_size;
    logic [BYTE_W-1:0]    payload_byte;
    logic                 last_of_record;
    logic                 truncated;
  } result_t;

  // up to two results produced by one input byte, in order
  typedef struct packed {
    logic    vld0;
    logic    vld1;
    result_t r0;
    result_t r1;
  } push_t;

  // indices at or above the slot count are never registered
  function automatic logic handler_on(input logic [HANDLER_SLOTS-1:0] mask,
                                      input logic [HANDLER_W-1:0] idx);
    logic on;
    on = 1'b0;
    if ({1'b0, idx} < (HANDLER_W+1)'(HANDLER_SLOTS)) begin
      on = mask[idx];
    end
    return on;
  endfunction

endpackage

/* hdl/prdf_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prdf_parser: per-byte record parser
// tracks boundary / header / payload phase and forms the results of a byte
// ----------------------------------------------------------------------------
module prdf_parser (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 accept,
  input  logic [prdf_pkg::BYTE_W-1:0]          data_byte,
  input  logic                                 last_byte,
  input  logic [prdf_pkg::HANDLER_SLOTS-1:0]   enable_mask,
  output prdf_pkg::push_t                      push
);

  prdf_pkg::phase_t                    phase_r, phase_nxt;
  logic                                pad_taken_r, pad_taken_nxt;
  logic [prdf_pkg::BYTE_W-1:0]         header_low_r, header_low_nxt;
  logic [prdf_pkg::HANDLER_W-1:0]      handler_r, handler_nxt;
  logic [prdf_pkg::SIZE_W-1:0]         size_r, size_nxt;
  logic [prdf_pkg::SIZE_W-1:0]         bytes_left_r, bytes_left_nxt;
  logic                                enabled_r, enabled_nxt;

  prdf_pkg::phase_t                    phase_mid;
  logic                                res_vld;
  logic [1:0]                          res_kind;
  logic [prdf_pkg::BYTE_W-1:0]         res_byte;
  logic                                res_last;
  prdf_pkg::result_t                   res_a, res_s;

  always_comb begin
    phase_mid      = phase_r;
    pad_taken_nxt  = pad_taken_r;
    header_low_nxt = header_low_r;
    handler_nxt    = handler_r;
    size_nxt       = size_r;
    bytes_left_nxt = bytes_left_r;
    enabled_nxt    = enabled_r;
    res_vld        = 1'b0;
    res_kind       = prdf_pkg::KIND_PAYLOAD;
    res_byte       = '0;
    res_last       = 1'b0;

    unique case (phase_r)
      prdf_pkg::PH_BOUNDARY: begin
        if (data_byte == '0 && !pad_taken_r) begin
          pad_taken_nxt = 1'b1;
        end else begin
          header_low_nxt = data_byte;
          phase_mid      = prdf_pkg::PH_HDR_HIGH;
        end
      end
      prdf_pkg::PH_HDR_HIGH: begin
        // header is {data_byte, header_low}: handler bits 5:1, size bits 15:6
        handler_nxt    = header_low_r[5:1];
        size_nxt       = {data_byte, header_low_r[7:6]};
        enabled_nxt    = prdf_pkg::handler_on(enable_mask, header_low_r[5:1]);
        bytes_left_nxt = {data_byte, header_low_r[7:6]};
        pad_taken_nxt  = 1'b0;
        if ({data_byte, header_low_r[7:6]} == '0) begin
          res_vld   = enabled_nxt;
          res_kind  = prdf_pkg::KIND_MARKER;
          phase_mid = prdf_pkg::PH_BOUNDARY;
        end else begin
          phase_mid = prdf_pkg::PH_PAYLOAD;
        end
      end
      prdf_pkg::PH_PAYLOAD: begin
        bytes_left_nxt = bytes_left_r - 1'b1;
        res_vld        = enabled_r;
        res_kind       = prdf_pkg::KIND_PAYLOAD;
        res_byte       = data_byte;
        res_last       = (bytes_left_nxt == '0);
        if (bytes_left_nxt == '0) begin
          phase_mid = prdf_pkg::PH_BOUNDARY;
        end
      end
      default: begin
        phase_mid = prdf_pkg::PH_BOUNDARY;
      end
    endcase

    phase_nxt = phase_mid;
    if (last_byte) begin
      phase_nxt      = prdf_pkg::PH_BOUNDARY;
      pad_taken_nxt  = 1'b0;
      bytes_left_nxt = '0;
    end
  end

  always_comb begin
    res_a.kind           = res_kind;
    res_a.handler_index  = handler_nxt;
    res_a.record_size    = size_nxt;
    res_a.payload_byte   = res_byte;
    res_a.last_of_record = res_last;
    res_a.truncated      = 1'b0;

    res_s.kind           = prdf_pkg::KIND_STATUS;
    res_s.handler_index  = handler_nxt;
    res_s.record_size    = size_nxt;
    res_s.payload_byte   = '0;
    res_s.last_of_record = 1'b0;
    res_s.truncated      = (phase_mid != prdf_pkg::PH_BOUNDARY);

    // status result moves into the first slot when nothing precedes it
    push.vld0 = accept && (res_vld || last_byte);
    push.vld1 = accept && res_vld && last_byte;
    push.r0   = res_vld ? res_a : res_s;
    push.r1   = res_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= prdf_pkg::PH_BOUNDARY;
      pad_taken_r  <= 1'b0;
      header_low_r <= '0;
      handler_r    <= '0;
      size_r       <= '0;
      bytes_left_r <= '0;
      enabled_r    <= 1'b0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      pad_taken_r  <= pad_taken_nxt;
      header_low_r <= header_low_nxt;
      handler_r    <= handler_nxt;
      size_r       <= size_nxt;
      bytes_left_r <= bytes_left_nxt;
      enabled_r    <= enabled_nxt;
    end
  end

endmodule

/* hdl/prdf_result_q.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prdf_result_q: four-entry result queue
// takes up to two results a cycle, hands out one a cycle on valid / stall
// ----------------------------------------------------------------------------
module prdf_result_q (
  input  logic                clk,
  input  logic                rst_n,
  input  prdf_pkg::push_t     push,
  output logic                room2,
  output logic                out_valid,
  input  logic                out_stall,
  output prdf_pkg::result_t   head
);

  prdf_pkg::result_t mem [4];
  logic [1:0]        wr_ptr_r, wr_ptr_nxt;
  logic [1:0]        rd_ptr_r, rd_ptr_nxt;
  logic [2:0]        count_r, count_nxt;
  logic              pop;
  logic [1:0]        push_n;

  assign out_valid = (count_r != '0);
  assign room2     = (count_r <= 3'd2);
  assign head      = mem[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  assign push_n    = {push.vld0 && push.vld1, push.vld0 ^ push.vld1};

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + push_n;
    rd_ptr_nxt = rd_ptr_r + {1'b0, pop};
    count_nxt  = count_r + {1'b0, push_n} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (push.vld0) begin
      mem[wr_ptr_r] <= push.r0;
    end
    if (push.vld1) begin
      mem[wr_ptr_r + 2'd1] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* hdl/padded_record_deframer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// padded_record_deframer_top: splits a byte-wide command packet into records
// one byte per request in, payload / marker / status requests out
// ----------------------------------------------------------------------------
// usage
//   input: one packet byte per request (in_valid / in_stall), in_last_byte
//     marks the final byte of the packet
//   output: one result per request (out_valid / out_stall); a byte may give
//     none, one or two results (a payload byte or empty-record marker, then
//     the packet end status on the last byte)
//   config: cfg_handler_enable_mask is taken when cfg_valid is high; cfg_ready
//     is always high. write it only while the block is idle
//   results: those of a byte are registered into the queue as it is accepted
//   throughput: one byte per cycle unless in_stall; parser state updates
//     as each byte is accepted; results go through a four-entry queue
//   stall: the queue keeps absorbing bytes while out_stall is high; in_stall
//     rises once fewer than two queue entries are free
//   reset: parser returns to a record boundary, queue empties, mask clears
// ----------------------------------------------------------------------------
module padded_record_deframer_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // byte input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [prdf_pkg::BYTE_W-1:0]         in_data_byte,
  input  logic                                in_last_byte,
  // results
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_kind,
  output logic [prdf_pkg::HANDLER_W-1:0]      out_handler_index,
  output logic [prdf_pkg::SIZE_W-1:0]         out_record_size,
  output logic [prdf_pkg::BYTE_W-1:0]         out_payload_byte,
  output logic                                out_last_of_record,
  output logic                                out_truncated,
  // handler mask write
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [prdf_pkg::HANDLER_SLOTS-1:0]  cfg_handler_enable_mask
);

  logic [prdf_pkg::HANDLER_SLOTS-1:0] mask_r;
  logic                               room2;
  logic                               in_accept;
  prdf_pkg::push_t                    push;
  prdf_pkg::result_t                  head;

  // mask write is always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r <= '0;
    end else if (cfg_valid) begin
      mask_r <= cfg_handler_enable_mask;
    end
  end

  // a byte can make two results, so hold off unless two entries are free
  assign in_stall  = !room2;
  assign in_accept = in_valid && room2;

  prdf_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .data_byte   (in_data_byte),
    .last_byte   (in_last_byte),
    .enable_mask (mask_r),
    .push        (push)
  );

  prdf_result_q u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room2     (room2),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  // queue head straight onto the result ports
  assign out_kind           = head.kind;
  assign out_handler_index  = head.handler_index;
  assign out_record_size    = head.record_size;
  assign out_payload_byte   = head.payload_byte;
  assign out_last_of_record = head.last_of_record;
  assign out_truncated      = head.truncated;

endmodule
